// File: rtl/core/ahfe_pkg.sv
// shared constants for the async hdlc frame encoder with fcs-16
// no dependencies
package ahfe_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam int          BYTE_W    = 8;
    localparam int          FCS_W     = 16;

endpackage

// File: rtl/core/ahfe_fcs16.sv
// reflected crc-16 update over one byte, eight shift steps in one pass
// depends on ahfe_pkg
module ahfe_fcs16
(
    input  logic [ahfe_pkg::FCS_W-1:0]  fcs_in,
    input  logic [ahfe_pkg::BYTE_W-1:0] data,
    output logic [ahfe_pkg::FCS_W-1:0]  fcs_out
);

    always_comb
    begin
        logic [ahfe_pkg::FCS_W-1:0] crc;
        crc = fcs_in ^ {{(ahfe_pkg::FCS_W - ahfe_pkg::BYTE_W){1'b0}}, data};
        for (int i = 0; i < ahfe_pkg::BYTE_W; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ ahfe_pkg::FCS_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        fcs_out = crc;
    end

endmodule

// File: rtl/core/async_hdlc_frame_encoder_fcs16_core.sv
// top level of the async hdlc frame encoder: framing, byte stuffing, fcs-16
// depends on ahfe_pkg and ahfe_fcs16
// Each accepted body byte is held in one item register while a small
// sequencer sends its line bytes, one per cycle while the output is not
// stalled, into an output register: an opening flag when no frame is open,
// the stuffed byte, and after the last byte the stuffed complemented fcs
// (low byte first) and a closing flag. An item therefore produces from 1 up
// to 8 line bytes; plain body bytes inside a frame run at one item per
// cycle while the output is not stalled, and the next item is taken in the
// same cycle its predecessor's final byte moves to the output register. The
// fcs is updated over the whole byte in a single pass at the input transfer.
module async_hdlc_frame_encoder_fcs16_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // line_byte
    output logic       m_axis_tlast,   // run_last
    output logic       m_axis_tuser    // frame_close
);

    typedef enum logic [2:0]
    {
        ST_OPEN,
        ST_DATA,
        ST_FCSL,
        ST_FCSH,
        ST_CLOSE
    } step_t;

    logic                         inside_reg;
    logic [ahfe_pkg::FCS_W-1:0]   fcs_state_reg;

    logic                         hold_valid_reg;
    logic [ahfe_pkg::BYTE_W-1:0]  hold_byte_reg;
    logic                         hold_last_reg;
    logic [ahfe_pkg::FCS_W-1:0]   hold_fcs_reg;
    step_t                        step_reg;
    logic                         esc_done_reg;

    logic                         out_valid_reg;
    logic [ahfe_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_last_reg;
    logic                         out_close_reg;

    logic                         in_xfer;
    logic                         out_load;
    logic                         emit;
    logic                         emit_final;
    logic [ahfe_pkg::BYTE_W-1:0]  cur_byte;
    logic [ahfe_pkg::BYTE_W-1:0]  emit_byte;
    logic                         cur_stuff;
    logic                         emit_esc;
    logic                         emit_close;
    step_t                        step_next;
    logic [ahfe_pkg::FCS_W-1:0]   fcs_base;
    logic [ahfe_pkg::FCS_W-1:0]   fcs_new;

    ahfe_fcs16 u_fcs
    (
        .fcs_in  (fcs_base),
        .data    (s_axis_tdata),
        .fcs_out (fcs_new)
    );

    assign fcs_base = inside_reg ? fcs_state_reg : ahfe_pkg::FCS_INIT;

    always_comb
    begin
        unique case (step_reg)
            ST_OPEN:  cur_byte = ahfe_pkg::FLAG_BYTE;
            ST_DATA:  cur_byte = hold_byte_reg;
            ST_FCSL:  cur_byte = hold_fcs_reg[7:0];
            ST_FCSH:  cur_byte = hold_fcs_reg[15:8];
            ST_CLOSE: cur_byte = ahfe_pkg::FLAG_BYTE;
            default:  cur_byte = ahfe_pkg::FLAG_BYTE;
        endcase

        cur_stuff = (step_reg == ST_DATA || step_reg == ST_FCSL || step_reg == ST_FCSH)
                    && (cur_byte == ahfe_pkg::FLAG_BYTE || cur_byte == ahfe_pkg::ESC_BYTE);
        emit_esc   = cur_stuff && !esc_done_reg;
        emit_close = (step_reg == ST_CLOSE);

        if (emit_esc)
        begin
            emit_byte = ahfe_pkg::ESC_BYTE;
        end
        else if (cur_stuff)
        begin
            emit_byte = cur_byte ^ ahfe_pkg::ESC_XOR;
        end
        else
        begin
            emit_byte = cur_byte;
        end

        emit_final = emit_close || (step_reg == ST_DATA && !hold_last_reg && !emit_esc);

        unique case (step_reg)
            ST_OPEN:  step_next = ST_DATA;
            ST_DATA:  step_next = ST_FCSL;
            ST_FCSL:  step_next = ST_FCSH;
            ST_FCSH:  step_next = ST_CLOSE;
            ST_CLOSE: step_next = ST_CLOSE;
            default:  step_next = ST_CLOSE;
        endcase
    end

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign emit          = hold_valid_reg && out_load;
    assign s_axis_tready = !hold_valid_reg || (emit && emit_final);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg     <= 1'b0;
            fcs_state_reg  <= ahfe_pkg::FCS_INIT;
            hold_valid_reg <= 1'b0;
            step_reg       <= ST_OPEN;
            esc_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_close_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= emit;
            end

            if (emit)
            begin
                out_byte_reg  <= emit_byte;
                out_last_reg  <= emit_final;
                out_close_reg <= emit_close;
            end

            if (in_xfer)
            begin
                hold_valid_reg <= 1'b1;
                step_reg       <= inside_reg ? ST_DATA : ST_OPEN;
                esc_done_reg   <= 1'b0;
                inside_reg     <= !s_axis_tlast;
                fcs_state_reg  <= s_axis_tlast ? ahfe_pkg::FCS_INIT : fcs_new;
            end
            else if (emit)
            begin
                if (emit_final)
                begin
                    hold_valid_reg <= 1'b0;
                    esc_done_reg   <= 1'b0;
                end
                else if (emit_esc)
                begin
                    esc_done_reg <= 1'b1;
                end
                else
                begin
                    esc_done_reg <= 1'b0;
                    step_reg     <= step_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_byte_reg <= s_axis_tdata;
            hold_last_reg <= s_axis_tlast;
            hold_fcs_reg  <= fcs_new ^ ahfe_pkg::FCS_INIT;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_close_reg;

endmodule
